// ===== sv/delimited_field_extractor_assert.svh =====
// Assertion macros shared by the delimited field extractor RTL.
`ifndef DELIMITED_FIELD_EXTRACTOR_ASSERT_SVH
`define DELIMITED_FIELD_EXTRACTOR_ASSERT_SVH

// Check a same-cycle implication, disabled while reset is held.
`define DFX_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, disabled while reset is held.
`define DFX_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dfx_pkg.sv =====
// Shared constants, types and helpers of the delimited field extractor.
package dfx_pkg;

    localparam int SEP_MAX     = 4;
    localparam int SEP_REG_BYTES = 4;
    localparam int WIN_DEPTH   = (SEP_MAX < SEP_REG_BYTES) ? SEP_MAX : SEP_REG_BYTES;
    localparam int BYTE_W      = 8;
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    localparam int CNT_W       = 16;
    localparam int SEP_LEN_W   = 3;
    localparam int SEP_BYTES_W = 32;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REG_SEP_BYTES = 2'd0,
        REG_SEP_LEN   = 2'd1,
        REG_FIELD_IDX = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SEP_BYTES_W-1:0] sep_bytes;
        logic [SEP_LEN_W-1:0]   sep_len;
        logic [CNT_W-1:0]       field_idx;
    } t_cfg;

    // All results caused by one input request: data bytes first, then an
    // optional end marker.
    typedef struct packed {
        logic [WIN_DEPTH-1:0][BYTE_W-1:0] data;
        logic [FILL_W-1:0]                ndata;
        logic                             has_end;
        logic                             found;
    } t_bundle;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Clamp the programmed separator length into 1..WIN_DEPTH.
    function automatic logic [FILL_W-1:0] eff_len(input logic [SEP_LEN_W-1:0] raw);
        logic [SEP_LEN_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = SEP_LEN_W'(1);
        end else if (raw > SEP_LEN_W'(WIN_DEPTH)) begin
            v = SEP_LEN_W'(WIN_DEPTH);
        end
        return FILL_W'(v);
    endfunction

endpackage

// ===== sv/dfx_cfg.sv =====
// APB register file holding separator and field selection settings.
module dfx_cfg
    import dfx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep_bytes <= SEP_BYTES_W'(44);
            r_cfg.sep_len   <= SEP_LEN_W'(1);
            r_cfg.field_idx <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_SEP_BYTES: r_cfg.sep_bytes <= pwdata[SEP_BYTES_W-1:0];
                REG_SEP_LEN:   r_cfg.sep_len   <= pwdata[SEP_LEN_W-1:0];
                REG_FIELD_IDX: r_cfg.field_idx <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_SEP_BYTES: prdata = APB_DATA_W'(r_cfg.sep_bytes);
            REG_SEP_LEN:   prdata = APB_DATA_W'(r_cfg.sep_len);
            REG_FIELD_IDX: prdata = APB_DATA_W'(r_cfg.field_idx);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/dfx_front.sv =====
// Front end: look-ahead window, separator match and field counting.
module dfx_front
    import dfx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output t_bundle           o_bundle
);

    logic [WIN_DEPTH-1:0][BYTE_W-1:0] r_win, n_win;
    logic [FILL_W-1:0]                r_fill, n_fill;
    logic [CNT_W-1:0]                 r_passed, n_passed;
    logic                             r_fin, n_fin;
    logic                             accept;
    t_bundle                          bundle;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_push   = accept && ((bundle.ndata != '0) || bundle.has_end);
    assign o_bundle = bundle;

    always_comb begin
        logic [WIN_DEPTH-1:0][BYTE_W-1:0] shifted;
        logic [FILL_W-1:0]                len;
        logic                             match;
        logic                             sel;
        n_win    = r_win;
        n_fill   = r_fill;
        n_passed = r_passed;
        n_fin    = r_fin;
        bundle   = '0;
        len      = eff_len(i_cfg.sep_len);
        match    = 1'b0;
        sel      = 1'b0;
        shifted  = '0;
        if (!r_fin) begin
            // Append the new byte behind the bytes still waiting.
            for (int j = 0; j < WIN_DEPTH; j++) begin
                if (FILL_W'(j) == r_fill) begin
                    n_win[j] = i_byte;
                end
            end
            n_fill = r_fill + 1'b1;
            // Each step retires at least one byte, so WIN_DEPTH steps drain it.
            for (int it = 0; it < WIN_DEPTH; it++) begin
                if (!n_fin && (n_fill >= len)) begin
                    match = 1'b1;
                    for (int k = 0; k < WIN_DEPTH; k++) begin
                        if ((FILL_W'(k) < len) &&
                            (n_win[k] != i_cfg.sep_bytes[BYTE_W*k +: BYTE_W])) begin
                            match = 1'b0;
                        end
                    end
                    sel = (n_passed == i_cfg.field_idx);
                    if (match) begin
                        if (sel) begin
                            bundle.has_end = 1'b1;
                            bundle.found   = 1'b1;
                            n_fin          = 1'b1;
                            n_fill         = '0;
                        end else begin
                            if (n_passed != '1) begin
                                n_passed = n_passed + 1'b1;
                            end
                            shifted = '0;
                            for (int j = 0; j < WIN_DEPTH; j++) begin
                                for (int s = 1; s <= WIN_DEPTH; s++) begin
                                    if ((FILL_W'(s) == len) && (j + s < WIN_DEPTH)) begin
                                        shifted[j] = n_win[j+s];
                                    end
                                end
                            end
                            n_win  = shifted;
                            n_fill = n_fill - len;
                        end
                    end else begin
                        if (sel) begin
                            for (int j = 0; j < WIN_DEPTH; j++) begin
                                if (FILL_W'(j) == bundle.ndata) begin
                                    bundle.data[j] = n_win[0];
                                end
                            end
                            bundle.ndata = bundle.ndata + 1'b1;
                        end
                        shifted = '0;
                        for (int j = 0; j + 1 < WIN_DEPTH; j++) begin
                            shifted[j] = n_win[j+1];
                        end
                        n_win  = shifted;
                        n_fill = n_fill - 1'b1;
                    end
                end
            end
            // End of string: flush the short tail as data, then close the field.
            if (i_last && !n_fin) begin
                sel = (n_passed == i_cfg.field_idx);
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    if (sel && (FILL_W'(k) < n_fill)) begin
                        for (int j = 0; j < WIN_DEPTH; j++) begin
                            if (FILL_W'(j) == bundle.ndata) begin
                                bundle.data[j] = n_win[k];
                            end
                        end
                        bundle.ndata = bundle.ndata + 1'b1;
                    end
                end
                bundle.has_end = 1'b1;
                bundle.found   = sel;
            end
        end
        if (i_last) begin
            n_win    = '0;
            n_fill   = '0;
            n_passed = '0;
            n_fin    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_fill   <= '0;
            r_passed <= '0;
            r_fin    <= 1'b0;
        end else if (accept) begin
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_passed <= n_passed;
            r_fin    <= n_fin;
        end
    end

endmodule

// ===== sv/dfx_queue.sv =====
// Short result-bundle queue between the front and back ends.
module dfx_queue
    import dfx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bundle   i_bundle,
    input  logic      i_pop,
    output t_bundle   o_head,
    output t_q_status o_status
);

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/dfx_back.sv =====
// Back end: unpacks bundles into single results behind an output register.
module dfx_back
    import dfx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bundle           i_head,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_is_data,
    output logic              o_found,
    output logic              o_last
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_is_data;
    logic              r_found;
    logic              r_last;
    logic [FILL_W-1:0] r_pos;

    logic              load;
    logic              is_data;
    logic              final_res;
    logic [BYTE_W-1:0] cur_byte;

    assign load      = !i_q_empty && (!r_valid || i_ready);
    assign is_data   = (r_pos < i_head.ndata);
    assign final_res = is_data ? (((r_pos + 1'b1) == i_head.ndata) && !i_head.has_end)
                               : 1'b1;
    assign o_pop     = load && final_res;

    always_comb begin
        cur_byte = '0;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            if (FILL_W'(j) == r_pos) begin
                cur_byte = i_head.data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= final_res ? '0 : r_pos + 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= is_data ? cur_byte : '0;
            r_is_data <= is_data;
            r_found   <= !is_data && i_head.found;
            r_last    <= !is_data;
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_is_data = r_is_data;
    assign o_found   = r_found;
    assign o_last    = r_last;

endmodule

// ===== sv/delimited_field_extractor.sv =====
// Top level of the delimited field extractor: stream in, selected field out.
// A byte's first result passes through the bundle queue and then the output register.
// The front end takes one byte per cycle while the 4-entry bundle queue has room;
// the back end drains one result per cycle while the output is ready.
// Synchronous active-low reset empties the queue and output register and restores
// the separator to a single comma and field index 0.
`include "delimited_field_extractor_assert.svh"

module delimited_field_extractor
    import dfx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // text in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] text_byte
    input  logic                  s_axis_tlast,  // end_of_string
    // field out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BYTE_W-1:0]     m_axis_tdata,  // [7:0] field_byte
    output logic [1:0]            m_axis_tuser,  // [0] is_data, [1] field_found
    output logic                  m_axis_tlast   // last_of_run
);

    t_cfg      cfg;
    t_bundle   push_bundle;
    t_bundle   head;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic      out_is_data;
    logic      out_found;
    logic      end_out;
    logic      data_out;

    // Register file: separator pattern, its length and the field to select.
    dfx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front end: take one byte per cycle while the queue has room, resolve separators
    // in the window and collect every result that byte causes into one bundle.
    dfx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // Queue: decouple the byte rate from the result rate so each side stalls alone.
    dfx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Back end: walk the head bundle one result per cycle, while the output is ready,
    // into the output register; pop the bundle with its final result.
    dfx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_status.empty),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_is_data (out_is_data),
        .o_found   (out_found),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = {out_found, out_is_data};

    // Offered end marker and offered data result.
    assign end_out  = m_axis_tvalid && !out_is_data;
    assign data_out = m_axis_tvalid && out_is_data;

    // An end marker closes the run and carries no byte.
    `DFX_CHECK(a_end_form, end_out, m_axis_tlast && !(|m_axis_tdata), "malformed end marker")
    // Data results never close the run or report a found flag.
    `DFX_CHECK(a_data_form, data_out, !m_axis_tlast && !out_found, "malformed data result")
    // The back end only retires a bundle that is present in the queue.
    `DFX_CHECK(a_pop_nonempty, pop, !q_status.empty, "bundle popped from an empty queue")

endmodule
